FILE: src/rgb_kernel_convolution_top_assert.svh
// assertion macros for the convolution block
`ifndef RGB_KERNEL_CONVOLUTION_TOP_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_TOP_ASSERT_SVH

// property checked outside reset
`define RKC_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rkc assertion failed");

// property checked on every edge, reset included
`define RKC_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rkc assertion failed");

`endif

FILE: src/rkc_pkg.sv
package rkc_pkg;

   localparam int PIX_W      = 24;
   localparam int CH_W       = 8;
   localparam int COEF_W     = 16;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam int WIDTH_W    = 12;
   localparam int ORDER_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ORDER = 1'd1;

   // item codes
   localparam logic OP_COEF  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   typedef struct packed {
      logic valid;
      logic last;
   } rkc_tag_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last;
   } rkc_result_type;

endpackage

FILE: src/rkc_line_mem.sv
module rkc_line_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 144
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] line_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic [DATA_W-1:0] wr_last_ff;
   logic              fwd_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
         wr_last_ff           <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= line_mem_ff[rd_addr];
         fwd_ff  <= wr_en && (wr_addr == rd_addr);
      end
   end

   // a read that met a write to the same entry takes the written word
   assign rd_data = fwd_ff ? wr_last_ff : rd_q_ff;

endmodule

FILE: src/rkc_window_mac.sv
module rkc_window_mac #(
   parameter int MAX_ORDER      = 7,
   parameter int COEF_FRAC_BITS = 12,
   parameter int ORD_W          = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  shift_en,
   input  logic [MAX_ORDER*rkc_pkg::PIX_W-1:0]   col_data,
   input  rkc_pkg::rkc_tag_type                  tag_in,
   input  logic                                  coef_we,
   input  logic [rkc_pkg::IDX_W-1:0]             coef_idx,
   input  logic signed [rkc_pkg::COEF_W-1:0]     coef_value,
   input  logic [ORD_W-1:0]                      order,
   output logic                                  res_valid,
   output rkc_pkg::rkc_result_type               res
);
   import rkc_pkg::*;

   localparam int NW     = MAX_ORDER * MAX_ORDER;
   localparam int WT_AW  = (NW > 1) ? $clog2(NW) : 1;
   localparam int PROD_W = CH_W + 1 + COEF_W;
   localparam int RSUM_W = PROD_W + $clog2(MAX_ORDER + 1);
   localparam int TOT_W  = RSUM_W + $clog2(MAX_ORDER + 1);

   logic [PIX_W-1:0]         win_ff  [MAX_ORDER][MAX_ORDER];
   logic signed [COEF_W-1:0] wt_ff   [NW];
   logic signed [COEF_W-1:0] ew_ff   [MAX_ORDER][MAX_ORDER];
   logic signed [COEF_W-1:0] ew_in   [MAX_ORDER][MAX_ORDER];
   logic                     use_ff  [MAX_ORDER][MAX_ORDER];
   logic                     use_in  [MAX_ORDER][MAX_ORDER];
   logic signed [PROD_W-1:0] prod_ff [MAX_ORDER][MAX_ORDER][3];
   logic signed [RSUM_W-1:0] rsum_ff [MAX_ORDER][3];
   logic signed [RSUM_W-1:0] rsum_in [MAX_ORDER][3];
   logic signed [TOT_W-1:0]  tot_ff  [3];
   logic signed [TOT_W-1:0]  tot_in  [3];
   logic [CH_W-1:0]          chan    [3];
   rkc_tag_type              tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   // window: shift left, new column enters on the right, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_ORDER; j++) begin
            for (int c = 0; c < MAX_ORDER; c++) win_ff[j][c] <= '0;
         end
      end else if (shift_en) begin
         for (int j = 0; j < MAX_ORDER; j++) begin
            for (int c = 0; c < MAX_ORDER - 1; c++) win_ff[j][c] <= win_ff[j][c+1];
            win_ff[j][MAX_ORDER-1] <= col_data[j*PIX_W +: PIX_W];
         end
      end
   end

   // weight table, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) wt_ff[k] <= '0;
      end else if (coef_we && (32'(coef_idx) < 32'(NW))) begin
         wt_ff[WT_AW'(coef_idx)] <= coef_value;
      end
   end

   // weight seen by each window position under the current order
   always_comb begin
      int ord;
      int k;
      ord = int'(order);
      k = 0;
      for (int j = 0; j < MAX_ORDER; j++) begin
         for (int c = 0; c < MAX_ORDER; c++) begin
            if ((j < ord) && (c >= MAX_ORDER - ord)) begin
               k = j * ord + c - (MAX_ORDER - ord);
               ew_in[j][c]  = wt_ff[WT_AW'(k)];
               use_in[j][c] = 1'b1;
            end else begin
               ew_in[j][c]  = '0;
               use_in[j][c] = 1'b0;
            end
         end
      end
   end

   // products, one per position and channel; positions outside the kernel give zero
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
         for (int c = 0; c < MAX_ORDER; c++) begin
            ew_ff[j][c]  <= ew_in[j][c];
            use_ff[j][c] <= use_in[j][c];
            for (int h = 0; h < 3; h++) begin
               if (use_ff[j][c]) begin
                  prod_ff[j][c][h] <=
                     $signed({1'b0, win_ff[j][c][PIX_W-1-CH_W*h -: CH_W]}) * ew_ff[j][c];
               end else begin
                  prod_ff[j][c][h] <= '0;
               end
            end
         end
      end
   end

   // row sums
   always_comb begin
      for (int j = 0; j < MAX_ORDER; j++) begin
         for (int h = 0; h < 3; h++) begin
            rsum_in[j][h] = '0;
            for (int c = 0; c < MAX_ORDER; c++) begin
               rsum_in[j][h] = rsum_in[j][h] + RSUM_W'(prod_ff[j][c][h]);
            end
         end
      end
   end

   // totals over rows
   always_comb begin
      for (int h = 0; h < 3; h++) begin
         tot_in[h] = '0;
         for (int j = 0; j < MAX_ORDER; j++) tot_in[h] = tot_in[h] + TOT_W'(rsum_ff[j][h]);
      end
   end

   always_ff @(posedge clock) begin
      rsum_ff <= rsum_in;
      tot_ff  <= tot_in;
   end

   // stage flags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag2_ff <= shift_en ? tag_in : '0;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   // floor and clamp to 0..255
   always_comb begin
      logic signed [TOT_W-1:0] sh;
      for (int h = 0; h < 3; h++) begin
         sh = tot_ff[h] >>> COEF_FRAC_BITS;
         if (tot_ff[h][TOT_W-1]) begin
            chan[h] = '0;
         end else if (sh > TOT_W'(CH_MAX)) begin
            chan[h] = CH_MAX;
         end else begin
            chan[h] = sh[CH_W-1:0];
         end
      end
   end

   assign res_valid = tag5_ff.valid;
   assign res.red   = chan[0];
   assign res.green = chan[1];
   assign res.blue  = chan[2];
   assign res.last  = tag5_ff.last;

endmodule

FILE: src/rkc_out_fifo.sv
module rkc_out_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rkc_pkg::rkc_result_type push_data,
   input  logic                    out_stall,
   output logic                    out_valid,
   output rkc_pkg::rkc_result_type out_data
);
   import rkc_pkg::*;

   rkc_result_type       fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = fifo_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   // storage
   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: src/rgb_kernel_convolution_top.sv
// a full-window pixel's result passes line read, window, products, row sums, totals and queue
// throughput: one word per cycle while the input is not stalled, weight loads and pixels alike
// input stalls only while 8 results are in flight or waiting at the output
// the line store read and write back on one memory port pair sets the one-cycle rate
// synchronous reset clears flags, window, weights, counters and queue; line store is not cleared
module rgb_kernel_convolution_top #(
   parameter int MAX_ORDER      = 7,
   parameter int MAX_WIDTH      = 2048,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic                                 req_frame_start,
   input  logic [rkc_pkg::CH_W-1:0]             req_red_in,
   input  logic [rkc_pkg::CH_W-1:0]             req_green_in,
   input  logic [rkc_pkg::CH_W-1:0]             req_blue_in,
   input  logic [rkc_pkg::IDX_W-1:0]            req_coef_index,
   input  logic signed [rkc_pkg::COEF_W-1:0]    req_coef_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rkc_pkg::CH_W-1:0]             rsp_red_out,
   output logic [rkc_pkg::CH_W-1:0]             rsp_green_out,
   output logic [rkc_pkg::CH_W-1:0]             rsp_blue_out,
   output logic                                 rsp_row_end,
   input  logic                                 csr_we,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rkc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import rkc_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ORD_W  = $clog2(MAX_ORDER + 1);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int LINES  = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
   localparam int LINE_W = LINES * PIX_W;

   logic [WIDTH_W-1:0]        image_width_ff;
   logic [ORDER_W-1:0]        kernel_order_ff;
   logic [ORD_W-1:0]          ord;
   logic [WID_W-1:0]          wid;
   logic [COL_W-1:0]          col_ff, col_cur, col_in;
   logic [ROW_W-1:0]          row_ff, row_cur, row_in;
   logic                      emit, last;
   logic                      accept, pix_acc, pop;
   logic [FIFO_AW:0]          pend_ff;
   logic                      v1_ff;
   rkc_tag_type               tag1_ff;
   logic [COL_W-1:0]          col1_ff;
   logic [PIX_W-1:0]          pix1_ff;
   logic [LINE_W-1:0]         rd_line, wr_line;
   logic [MAX_ORDER*PIX_W-1:0] col_vec;
   logic                      res_valid;
   rkc_result_type            res, out_data;

   assign accept  = req_valid && !req_stall;
   assign pix_acc = accept && (req_op == OP_PIXEL);
   assign pop     = rsp_valid && !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_W'(640);
         kernel_order_ff <= ORDER_W'(3);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_KERNEL_ORDER: kernel_order_ff <= csr_wdata[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // effective order and width
   always_comb begin
      if (kernel_order_ff == '0) ord = ORD_W'(1);
      else if (32'(kernel_order_ff) > 32'(MAX_ORDER)) ord = ORD_W'(MAX_ORDER);
      else ord = ORD_W'(kernel_order_ff);
      if (image_width_ff == '0) wid = WID_W'(1);
      else if (32'(image_width_ff) > 32'(MAX_WIDTH)) wid = WID_W'(MAX_WIDTH);
      else wid = WID_W'(image_width_ff);
   end

   // raster position
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      emit    = (int'(col_cur) + 1 >= int'(ord)) && (int'(row_cur) + 1 >= int'(ord));
      last    = (int'(col_cur) + 1 >= int'(wid));
      if (last) begin
         col_in = '0;
         if (int'(row_cur) + 1 < int'(ord)) row_in = row_cur + 1'b1;
         else row_in = ROW_W'(int'(ord) - 1);
      end else begin
         col_in = col_cur + 1'b1;
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // results owed: counted on acceptance, released on delivery
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         if ((pix_acc && emit) && !pop) pend_ff <= pend_ff + 1'b1;
         else if (pop && !(pix_acc && emit)) pend_ff <= pend_ff - 1'b1;
      end
   end

   assign req_stall = (32'(pend_ff) >= 32'(FIFO_DEPTH));

   // stage one: line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         tag1_ff <= '0;
      end else begin
         v1_ff         <= pix_acc;
         tag1_ff.valid <= pix_acc && emit;
         tag1_ff.last  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         col1_ff <= col_cur;
         pix1_ff <= {req_red_in, req_green_in, req_blue_in};
      end
   end

   rkc_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W),
      .DATA_W (LINE_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (pix_acc),
      .rd_addr (col_cur),
      .wr_en   (v1_ff),
      .wr_addr (col1_ff),
      .wr_data (wr_line),
      .rd_data (rd_line)
   );

   // new window column and the pushed-down line word
   always_comb begin
      int ord_i;
      ord_i = int'(ord);
      for (int j = 0; j < MAX_ORDER; j++) begin
         if (j == ord_i - 1) col_vec[j*PIX_W +: PIX_W] = pix1_ff;
         else if (j < ord_i - 1) col_vec[j*PIX_W +: PIX_W] = rd_line[(ord_i-2-j)*PIX_W +: PIX_W];
         else col_vec[j*PIX_W +: PIX_W] = '0;
      end
      for (int r = 0; r < LINES; r++) begin
         if (r == 0) wr_line[r*PIX_W +: PIX_W] = pix1_ff;
         else wr_line[r*PIX_W +: PIX_W] = rd_line[(r-1)*PIX_W +: PIX_W];
      end
   end

   rkc_window_mac #(
      .MAX_ORDER      (MAX_ORDER),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ORD_W          (ORD_W)
   ) u_window_mac (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (v1_ff),
      .col_data   (col_vec),
      .tag_in     (tag1_ff),
      .coef_we    (accept && (req_op == OP_COEF)),
      .coef_idx   (req_coef_index),
      .coef_value (req_coef_value),
      .order      (ord),
      .res_valid  (res_valid),
      .res        (res)
   );

   rkc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_red_out   = out_data.red;
   assign rsp_green_out = out_data.green;
   assign rsp_blue_out  = out_data.blue;
   assign rsp_row_end   = out_data.last;

endmodule

FILE: src/rkc_checker.sv
module rkc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic       rsp_row_end
);
`include "rgb_kernel_convolution_top_assert.svh"

   // a held result word stays offered
   `RKC_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // a held result word keeps its payload
   `RKC_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_row_end))

   // no result word is offered right after reset
   `RKC_ASSERT(a_rst_quiet, clock, reset |=> !rsp_valid ##1 !rsp_valid)

   // input is open right after reset
   `RKC_ASSERT(a_rst_ready, clock, reset |=> !req_stall)

endmodule

bind rgb_kernel_convolution_top rkc_checker u_rkc_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import rkc_pkg::*;

   typedef struct {
      bit             op;
      bit             fs;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic [5:0]     idx;
      logic [15:0]    coef;
      bit             typed;
      rkc_result_type res;
   } word_t;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_op;
   logic                req_frame_start;
   logic [CH_W-1:0]     req_red_in;
   logic [CH_W-1:0]     req_green_in;
   logic [CH_W-1:0]     req_blue_in;
   logic [IDX_W-1:0]    req_coef_index;
   logic signed [COEF_W-1:0] req_coef_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CH_W-1:0]     rsp_red_out;
   logic [CH_W-1:0]     rsp_green_out;
   logic [CH_W-1:0]     rsp_blue_out;
   logic                rsp_row_end;
   logic                csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic [PIX_W-1:0]    line_mem [0:6][0:2047];
   logic [PIX_W-1:0]    win [0:6][0:6];
   logic [COEF_W-1:0]   weights [0:48];
   int unsigned         col_pos;
   int unsigned         row_pos;
   logic [11:0]         width_reg;
   logic [2:0]          order_reg;

   rkc_result_type      pending_pixels [$];
   int                  mismatches;
   int                  burst_left;
   bit                  hold_request;
   int                  hold_left;
   int                  mode_cnt;
   int                  stall_mode;

   rgb_kernel_convolution_top dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [7:0] floor_clamp(longint s);
      longint v;
      if (s < 0) return 8'd0;
      v = s >>> 12;
      if (v > 255) return CH_MAX;
      return v[7:0];
   endfunction

   // weight load or pixel shift through line store and window
   function automatic bit convolve_word(word_t w, output rkc_result_type res);
      int unsigned ord, wid, c;
      logic [PIX_W-1:0] colv [0:6];
      logic [PIX_W-1:0] p;
      longint sr, sg, sb, k;
      bit emit, last;
      sr = 0;
      sg = 0;
      sb = 0;
      res = '0;
      if (w.op == OP_COEF) begin
         if (w.idx < 49) weights[w.idx] = w.coef;
         return 1'b0;
      end
      ord = (order_reg == 0) ? 1 : order_reg;
      wid = (width_reg == 0) ? 1 : ((width_reg > 2048) ? 2048 : width_reg);
      if (w.fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = (col_pos >= 2048) ? 2047 : col_pos;
      p = {w.red, w.green, w.blue};
      for (int j = 0; j < 7; j++) colv[j] = '0;
      colv[ord-1] = p;
      for (int r = 0; r + 1 < ord; r++) colv[ord-2-r] = line_mem[r][c];
      for (int r = 6; r > 0; r--) line_mem[r][c] = line_mem[r-1][c];
      line_mem[0][c] = p;
      for (int j = 0; j < 7; j++) begin
         for (int i = 0; i < 6; i++) win[j][i] = win[j][i+1];
         win[j][6] = colv[j];
      end
      emit = (c + 1 >= ord) && (row_pos + 1 >= ord);
      last = (c + 1 >= wid);
      if (last) begin
         col_pos = 0;
         row_pos = (row_pos + 1 < ord) ? row_pos + 1 : ord - 1;
      end else begin
         col_pos = c + 1;
      end
      if (!emit) return 1'b0;
      for (int j = 0; j < ord; j++) begin
         for (int i = 0; i < ord; i++) begin
            p = win[j][7-ord+i];
            k = $signed(weights[j*ord+i]);
            sr += longint'(p[23:16]) * k;
            sg += longint'(p[15:8]) * k;
            sb += longint'(p[7:0]) * k;
         end
      end
      res.red = floor_clamp(sr);
      res.green = floor_clamp(sg);
      res.blue = floor_clamp(sb);
      res.last = last;
      return 1'b1;
   endfunction

   // offer one word, wait for acceptance, then book its result
   task automatic send_word(word_t w);
      rkc_result_type res;
      req_valid <= 1'b1;
      req_op <= w.op;
      req_frame_start <= w.fs;
      req_red_in <= w.red;
      req_green_in <= w.green;
      req_blue_in <= w.blue;
      req_coef_index <= w.idx;
      req_coef_value <= w.coef;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (convolve_word(w, res)) pending_pixels.push_back(w.typed ? w.res : res);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
      end
   endtask

   // drain, let the pipeline settle, then program one register
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = val;
      else order_reg = val[2:0];
   endtask

   function automatic word_t rand_coef();
      word_t w;
      w = '{default: '0};
      w.op = OP_COEF;
      w.fs = $urandom_range(0, 1);
      w.red = $urandom;
      w.green = $urandom;
      w.blue = $urandom;
      w.idx = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 63) : $urandom_range(0, 48);
      case ($urandom_range(0, 3))
         0: w.coef = $urandom;
         1: w.coef = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: w.coef = $urandom_range(0, 1600) - 400;
      endcase
      return w;
   endfunction

   function automatic word_t rand_pixel(bit fs);
      word_t w;
      w = '{default: '0};
      w.op = OP_PIXEL;
      w.fs = fs;
      w.red = ($urandom_range(0, 7) == 0) ? 8'hff : $urandom;
      w.green = ($urandom_range(0, 7) == 0) ? 8'h00 : $urandom;
      w.blue = $urandom;
      w.idx = $urandom;
      w.coef = $urandom;
      return w;
   endfunction

   // one setting: fresh weights, then a frame with the odd weight load between words
   task automatic run_frame(int n_weights, int n_pixels);
      for (int n = 0; n < n_weights; n++) send_word(rand_coef());
      for (int n = 0; n < n_pixels; n++) begin
         if ($urandom_range(0, 19) == 0) send_word(rand_coef());
         send_word(rand_pixel(n == 0 || $urandom_range(0, 199) == 0));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rkc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%t unexpected word: red %0d green %0d blue %0d row_end %0d", $time,
                     rsp_red_out, rsp_green_out, rsp_blue_out, rsp_row_end);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red_out !== want.red) begin
               $display("%t red: expected %0d actual %0d", $time, want.red, rsp_red_out);
               mismatches++;
            end
            if (rsp_green_out !== want.green) begin
               $display("%t green: expected %0d actual %0d", $time, want.green,
                        rsp_green_out);
               mismatches++;
            end
            if (rsp_blue_out !== want.blue) begin
               $display("%t blue: expected %0d actual %0d", $time, want.blue, rsp_blue_out);
               mismatches++;
            end
            if (rsp_row_end !== want.last) begin
               $display("%t row_end: expected %0d actual %0d", $time, want.last,
                        rsp_row_end);
               mismatches++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         mode_cnt++;
         if (mode_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   initial begin
      word_t directed [0:13];
      mismatches = 0;
      burst_left = 5;
      hold_request = 1'b0;
      hold_left = 0;
      mode_cnt = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_COEF;
      req_frame_start = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      csr_we = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      width_reg = 12'd640;
      order_reg = 3'd3;
      col_pos = 0;
      row_pos = 0;
      for (int r = 0; r < 7; r++)
         for (int c = 0; c < 2048; c++) line_mem[r][c] = '0;
      for (int j = 0; j < 7; j++)
         for (int i = 0; i < 7; i++) win[j][i] = '0;
      for (int k = 0; k < 49; k++) weights[k] = '0;

      // one by one kernel, one pixel per row: each output reads straight off weight 0
      directed[0]  = '{OP_PIXEL, 1, 255, 255, 255, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}};
      directed[1]  = '{OP_COEF, 1, 9, 9, 9, 0, 16'h1000, 0, '0};
      directed[2]  = '{OP_PIXEL, 0, 12, 200, 255, 63, 16'hffff, 1,
                       '{8'd12, 8'd200, 8'd255, 1'b1}};
      directed[3]  = '{OP_COEF, 0, 0, 0, 0, 0, 16'h7fff, 0, '0};
      directed[4]  = '{OP_PIXEL, 1, 255, 0, 1, 0, 0, 1, '{8'd255, 8'd0, 8'd7, 1'b1}};
      directed[5]  = '{OP_COEF, 0, 0, 0, 0, 0, 16'h8000, 0, '0};
      directed[6]  = '{OP_PIXEL, 0, 255, 255, 255, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}};
      directed[7]  = '{OP_COEF, 0, 0, 0, 0, 63, 16'h1000, 0, '0};
      directed[8]  = '{OP_COEF, 0, 0, 0, 0, 48, 16'h1000, 0, '0};
      directed[9]  = '{OP_PIXEL, 0, 10, 20, 30, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}};
      directed[10] = '{OP_COEF, 0, 0, 0, 0, 0, 16'h0800, 0, '0};
      directed[11] = '{OP_PIXEL, 1, 3, 255, 0, 0, 0, 1, '{8'd1, 8'd127, 8'd0, 1'b1}};
      directed[12] = '{OP_COEF, 1, 255, 255, 255, 0, 16'h1000, 0, '0};
      directed[13] = '{OP_PIXEL, 0, 0, 128, 255, 0, 0, 0, '0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_IMAGE_WIDTH, 12'd1);
      write_reg(CSR_KERNEL_ORDER, 3'd1);
      foreach (directed[n]) send_word(directed[n]);

      // zero order and width act as one
      write_reg(CSR_IMAGE_WIDTH, 12'd0);
      write_reg(CSR_KERNEL_ORDER, 3'd0);
      run_frame(3, 40);

      // widest line with the smallest kernel
      write_reg(CSR_IMAGE_WIDTH, 12'd4095);
      run_frame(2, 150);
      write_reg(CSR_IMAGE_WIDTH, 12'd2048);
      write_reg(CSR_KERNEL_ORDER, 3'd1);
      run_frame(2, 150);

      // long receiver hold while words keep coming
      write_reg(CSR_IMAGE_WIDTH, 12'd16);
      write_reg(CSR_KERNEL_ORDER, 3'd3);
      hold_request = 1'b1;
      run_frame(9, 200);

      // line narrower than the kernel: no output at all
      write_reg(CSR_IMAGE_WIDTH, 12'd4);
      write_reg(CSR_KERNEL_ORDER, 3'd7);
      run_frame(5, 60);

      // largest kernel
      write_reg(CSR_IMAGE_WIDTH, 12'd9);
      run_frame(49, 200);
      write_reg(CSR_IMAGE_WIDTH, 12'd7);
      run_frame(20, 120);

      // width lowered part way through a row
      write_reg(CSR_IMAGE_WIDTH, 12'd10);
      write_reg(CSR_KERNEL_ORDER, 3'd2);
      run_frame(4, 37);
      write_reg(CSR_IMAGE_WIDTH, 12'd5);
      for (int n = 0; n < 30; n++) send_word(rand_pixel(1'b0));

      write_reg(CSR_IMAGE_WIDTH, 12'd3);
      write_reg(CSR_KERNEL_ORDER, 3'd3);
      run_frame(9, 120);
      write_reg(CSR_IMAGE_WIDTH, 12'd12);
      write_reg(CSR_KERNEL_ORDER, 3'd5);
      run_frame(25, 200);
      write_reg(CSR_IMAGE_WIDTH, 12'd640);
      write_reg(CSR_KERNEL_ORDER, 3'd3);
      run_frame(9, 30);
      write_reg(CSR_IMAGE_WIDTH, 12'd6);
      write_reg(CSR_KERNEL_ORDER, 3'd4);
      run_frame(16, 150);

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
